### rtl/core/evti_pkg.sv
// Shared types, codes and constant tables for the value table interpolator.
package evti_pkg;

  localparam int TABLE_POINTS = 256;
  localparam int IDX_W        = $clog2(TABLE_POINTS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int E_W          = 40;
  localparam int V_W          = 32;
  localparam int LG_W         = 22;

  localparam logic       OP_WRITE  = 1'b0;
  localparam logic       OP_QUERY  = 1'b1;
  localparam logic       REG_MODE  = 1'b0;
  localparam logic       REG_COUNT = 1'b1;
  localparam logic [3:0] MODE_LOGE = 4'd3;
  localparam logic [3:0] MODE_LOGV = 4'd4;
  localparam logic [3:0] MODE_RST  = 4'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BELOW = 2'd1;
  localparam logic [1:0] ST_ABOVE = 2'd2;
  localparam logic [1:0] ST_LOG0  = 2'd3;

  localparam logic [1:0] DST_L0 = 2'd0;
  localparam logic [1:0] DST_L1 = 2'd1;
  localparam logic [1:0] DST_LQ = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_FETCH_RD, S_FETCH_CAP, S_PLAN,
    S_LG_NORM, S_LG_MUL, S_LG_BIT, S_DIV, S_BLEND_MUL, S_BLEND_ADD,
    S_EXP_MUL, S_EXP_BIT, S_EXP_SHIFT
  } state_t;

  // c1 = isqrt(2^63), c(j+1) = isqrt(cj * 2^31)
  function automatic logic [16:1][31:0] gen_roots();
    logic [16:1][31:0] roots;
    logic [63:0] v, r, b, c;
    roots = '0;
    c = 64'h8000_0000_0000_0000;
    for (int j = 1; j <= 16; j++) begin
      v = c;
      r = '0;
      b = 64'h4000_0000_0000_0000;
      for (int s = 0; s < 32; s++) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      roots[j] = r[31:0];
      c = r << 31;
    end
    return roots;
  endfunction

  localparam logic [16:1][31:0] ROOTS = gen_roots();

endpackage

### rtl/core/endf_value_table_interpolator.sv
// Top level: table interpolator with point store, scan and shared arithmetic sequencer.
// Writes store one point and return one zero word on the cycle after acceptance. A query
// scans the table one slot at a time, with a read state and a compare state per slot, until
// it finds the first energy above the query, fetches the neighbor point, then runs a
// sequencer over one shared 32x32 multiplier and a bit-serial divider: the fraction is a
// bit-serial division, a blend a multiply then an add, each log2 a normalize loop then
// repeated squaring, exp2 a multiply by each root, kept where its fraction bit is set,
// then a shift. in_tready is low while a query is in work or a result word is still
// waiting at the output.
module endf_value_table_interpolator import evti_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // point_index[7:0], energy_in[47:8], value_in[79:48]
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_value
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wdata
);

  logic [E_W-1:0] energy_table [TABLE_POINTS];
  logic [V_W-1:0] value_table  [TABLE_POINTS];

  state_t          state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_data_r, out_data_nxt;
  logic [1:0]      out_user_r, out_user_nxt;
  logic [3:0]      mode_r;
  logic [8:0]      count_r;
  logic [E_W-1:0]  q_r, q_nxt, e0_r, e0_nxt, e1_r, e1_nxt;
  logic [V_W-1:0]  v0_r, v0_nxt, v1_r, v1_nxt;
  logic [CNT_W-1:0] n_r, n_nxt, i_r, i_nxt;
  logic [2:0]      step_r, step_nxt;
  logic [LG_W-1:0] l0_r, l0_nxt, l1_r, l1_nxt, lq_r, lq_nxt;
  logic [1:0]      lg_dst_r, lg_dst_nxt;
  logic [E_W-1:0]  norm_r, norm_nxt;
  logic [5:0]      k_r, k_nxt;
  logic [31:0]     m_r, m_nxt;
  logic [15:0]     f_r, f_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  logic [E_W-1:0]  rem_r, rem_nxt, den_r, den_nxt;
  logic [31:0]     t_r, t_nxt;
  logic [31:0]     ba_r, ba_nxt, bb_r, bb_nxt, bres_r, bres_nxt;
  logic            bge_r, bge_nxt;
  logic [31:0]     p_r, p_nxt;
  logic [4:0]      j_r, j_nxt;
  logic [63:0]     prod_r;

  logic [E_W-1:0]  rd_e_r;
  logic [V_W-1:0]  rd_v_r;
  logic [IDX_W-1:0] raddr;
  logic            mem_we;
  logic [31:0]     mul_a, mul_b;

  // sequencer helpers
  logic            fin;
  logic [31:0]     fin_val;
  logic [1:0]      fin_st;
  logic            lg_go;
  logic [E_W-1:0]  lg_x;
  logic [1:0]      lg_dst;
  logic            div_go, div_sat;
  logic [E_W-1:0]  div_num, div_den;
  logic            bl_go;
  logic [31:0]     bl_a, bl_b;
  logic [E_W-1:0]  lin_num, lin_den;
  logic [LG_W-1:0] log_num, log_den;
  logic [32:0]     sq;
  logic [E_W:0]    r2;
  logic [LG_W-1:0] lg_res;
  logic [4:0]      fidx;
  logic [15:0]     fbits;
  logic [5:0]      n_int;
  logic [8:0]      n_clip;

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign mem_we = in_tvalid && in_tready && (in_tuser == OP_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      energy_table[in_tdata[7:0]] <= in_tdata[47:8];
      value_table[in_tdata[7:0]]  <= in_tdata[79:48];
    end
    rd_e_r <= energy_table[raddr];
    rd_v_r <= value_table[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RST;
      count_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_MODE) mode_r <= cfg_wdata[3:0];
      else count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= {32'b0, mul_a} * {32'b0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;  out_user_r <= out_user_nxt;
    q_r <= q_nxt;    e0_r <= e0_nxt;  e1_r <= e1_nxt;
    v0_r <= v0_nxt;  v1_r <= v1_nxt;  n_r <= n_nxt;   i_r <= i_nxt;
    step_r <= step_nxt;  l0_r <= l0_nxt;  l1_r <= l1_nxt;  lq_r <= lq_nxt;
    lg_dst_r <= lg_dst_nxt;  norm_r <= norm_nxt;  k_r <= k_nxt;
    m_r <= m_nxt;  f_r <= f_nxt;  cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;  den_r <= den_nxt;  t_r <= t_nxt;
    ba_r <= ba_nxt;  bb_r <= bb_nxt;  bres_r <= bres_nxt;  bge_r <= bge_nxt;
    p_r <= p_nxt;  j_r <= j_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;  out_user_nxt = out_user_r;
    q_nxt = q_r;  e0_nxt = e0_r;  e1_nxt = e1_r;  v0_nxt = v0_r;  v1_nxt = v1_r;
    n_nxt = n_r;  i_nxt = i_r;  step_nxt = step_r;
    l0_nxt = l0_r;  l1_nxt = l1_r;  lq_nxt = lq_r;  lg_dst_nxt = lg_dst_r;
    norm_nxt = norm_r;  k_nxt = k_r;  m_nxt = m_r;  f_nxt = f_r;  cnt_nxt = cnt_r;
    rem_nxt = rem_r;  den_nxt = den_r;  t_nxt = t_r;
    ba_nxt = ba_r;  bb_nxt = bb_r;  bres_nxt = bres_r;  bge_nxt = bge_r;
    p_nxt = p_r;  j_nxt = j_r;
    raddr = i_r[IDX_W-1:0];
    mul_a = '0;
    mul_b = '0;
    fin = 1'b0;  fin_val = '0;  fin_st = ST_OK;
    lg_go = 1'b0;  lg_x = '0;  lg_dst = DST_L0;
    div_go = 1'b0;  div_sat = 1'b0;  div_num = '0;  div_den = '0;
    bl_go = 1'b0;  bl_a = '0;  bl_b = '0;
    lin_num = q_r - e0_r;
    lin_den = e1_r - e0_r;
    log_num = lq_r - l0_r;
    log_den = l1_r - l0_r;
    sq = prod_r[63:31];
    r2 = {rem_r, 1'b0};
    lg_res = '0;
    fidx = 5'd16 - j_r;
    fbits = bres_r[15:0];
    n_int = bres_r[21:16];
    n_clip = (count_r > 9'(TABLE_POINTS)) ? 9'(TABLE_POINTS) : count_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (in_tuser == OP_WRITE) begin
            fin = 1'b1;
          end else begin
            q_nxt = in_tdata[47:8];
            n_nxt = CNT_W'(n_clip);
            i_nxt = '0;
            if (n_clip == '0) begin
              fin = 1'b1;
              fin_st = ST_BELOW;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (rd_e_r > q_r) begin
          if (i_r == '0) begin
            fin = 1'b1;
            fin_st = ST_BELOW;
          end else begin
            e1_nxt = rd_e_r;
            v1_nxt = rd_v_r;
            state_nxt = S_FETCH_RD;
          end
        end else if (i_r + 1'b1 == n_r) begin
          fin = 1'b1;
          fin_st = ST_ABOVE;
        end else begin
          i_nxt = i_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_FETCH_RD: begin
        raddr = IDX_W'(i_r - 1'b1);
        state_nxt = S_FETCH_CAP;
      end
      S_FETCH_CAP: begin
        e0_nxt = rd_e_r;
        v0_nxt = rd_v_r;
        step_nxt = '0;
        state_nxt = S_PLAN;
      end
      S_PLAN: begin
        case (mode_r)
          MODE_LOGE: begin
            case (step_r)
              3'd0: begin
                if (e0_r == '0) begin
                  fin = 1'b1;
                  fin_st = ST_LOG0;
                end else begin
                  lg_go = 1'b1;  lg_x = e0_r;  lg_dst = DST_L0;
                end
              end
              3'd1: begin lg_go = 1'b1;  lg_x = e1_r;  lg_dst = DST_L1; end
              3'd2: begin lg_go = 1'b1;  lg_x = q_r;   lg_dst = DST_LQ; end
              3'd3: begin
                div_go = 1'b1;
                if (l1_r > l0_r) begin
                  div_num = E_W'(log_num);
                  div_den = E_W'(log_den);
                  // a query log below the lower log wraps in the fraction and saturates
                  div_sat = (lq_r < l0_r) || (log_num >= log_den);
                end else begin
                  div_num = lin_num;
                  div_den = lin_den;
                  div_sat = lin_num >= lin_den;
                end
              end
              3'd4: begin bl_go = 1'b1;  bl_a = v0_r;  bl_b = v1_r; end
              default: begin fin = 1'b1;  fin_val = bres_r; end
            endcase
          end
          MODE_LOGV: begin
            case (step_r)
              3'd0: begin
                if (v0_r == '0 || v1_r == '0) begin
                  fin = 1'b1;
                  fin_st = ST_LOG0;
                end else begin
                  div_go = 1'b1;  div_num = lin_num;  div_den = lin_den;
                  div_sat = lin_num >= lin_den;
                end
              end
              3'd1: begin lg_go = 1'b1;  lg_x = E_W'(v0_r);  lg_dst = DST_L0; end
              3'd2: begin lg_go = 1'b1;  lg_x = E_W'(v1_r);  lg_dst = DST_L1; end
              3'd3: begin bl_go = 1'b1;  bl_a = 32'(l0_r);  bl_b = 32'(l1_r); end
              3'd4: begin
                p_nxt = 32'h8000_0000;
                j_nxt = 5'd1;
                state_nxt = S_EXP_MUL;
              end
              default: begin fin = 1'b1;  fin_val = bres_r; end
            endcase
          end
          default: begin
            case (step_r)
              3'd0: begin
                div_go = 1'b1;  div_num = lin_num;  div_den = lin_den;
                div_sat = lin_num >= lin_den;
              end
              3'd1: begin bl_go = 1'b1;  bl_a = v0_r;  bl_b = v1_r; end
              default: begin fin = 1'b1;  fin_val = bres_r; end
            endcase
          end
        endcase
      end
      S_LG_NORM: begin
        if (norm_r[E_W-1]) begin
          m_nxt = norm_r[E_W-1 -: 32];
          f_nxt = '0;
          cnt_nxt = '0;
          state_nxt = S_LG_MUL;
        end else begin
          norm_nxt = {norm_r[E_W-2:0], 1'b0};
          k_nxt = k_r - 1'b1;
        end
      end
      S_LG_MUL: begin
        mul_a = m_r;
        mul_b = m_r;
        state_nxt = S_LG_BIT;
      end
      S_LG_BIT: begin
        f_nxt = {f_r[14:0], sq[32]};
        m_nxt = sq[32] ? sq[32:1] : sq[31:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd15) begin
          lg_res = {k_r, f_nxt};
          case (lg_dst_r)
            DST_L0:  l0_nxt = lg_res;
            DST_L1:  l1_nxt = lg_res;
            default: lq_nxt = lg_res;
          endcase
          step_nxt = step_r + 1'b1;
          state_nxt = S_PLAN;
        end else begin
          state_nxt = S_LG_MUL;
        end
      end
      S_DIV: begin
        if (r2 >= {1'b0, den_r}) begin
          rem_nxt = E_W'(r2 - {1'b0, den_r});
          t_nxt = {t_r[30:0], 1'b1};
        end else begin
          rem_nxt = r2[E_W-1:0];
          t_nxt = {t_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          step_nxt = step_r + 1'b1;
          state_nxt = S_PLAN;
        end
      end
      S_BLEND_MUL: begin
        mul_a = bge_r ? bb_r - ba_r : ba_r - bb_r;
        mul_b = t_r;
        state_nxt = S_BLEND_ADD;
      end
      S_BLEND_ADD: begin
        bres_nxt = bge_r ? ba_r + prod_r[63:32] : ba_r - prod_r[63:32];
        step_nxt = step_r + 1'b1;
        state_nxt = S_PLAN;
      end
      S_EXP_MUL: begin
        mul_a = p_r;
        mul_b = ROOTS[j_r];
        state_nxt = S_EXP_BIT;
      end
      S_EXP_BIT: begin
        if (fbits[fidx[3:0]]) p_nxt = prod_r[62:31];
        if (j_r == 5'd16) begin
          state_nxt = S_EXP_SHIFT;
        end else begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_EXP_MUL;
        end
      end
      S_EXP_SHIFT: begin
        bres_nxt = n_int[5] ? 32'hFFFF_FFFF : p_r >> (5'd31 - n_int[4:0]);
        step_nxt = step_r + 1'b1;
        state_nxt = S_PLAN;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (lg_go) begin
      norm_nxt = lg_x;
      k_nxt = 6'(E_W - 1);
      lg_dst_nxt = lg_dst;
      state_nxt = S_LG_NORM;
    end
    if (div_go) begin
      if (div_sat) begin
        t_nxt = 32'hFFFF_FFFF;
        step_nxt = step_r + 1'b1;
      end else begin
        rem_nxt = div_num;
        den_nxt = div_den;
        t_nxt = '0;
        cnt_nxt = '0;
        state_nxt = S_DIV;
      end
    end
    if (bl_go) begin
      ba_nxt = bl_a;
      bb_nxt = bl_b;
      bge_nxt = bl_b >= bl_a;
      state_nxt = S_BLEND_MUL;
    end
    if (fin) begin
      out_valid_nxt = 1'b1;
      out_data_nxt = fin_val;
      out_user_nxt = fin_st;
      state_nxt = S_IDLE;
    end
  end

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the value table interpolator: loads, queries and mode sweeps.
module testbench;
  import evti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // point_index[7:0], energy_in[47:8], value_in[79:48]
  logic        in_tuser;   // opcode
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // result_value
  logic [1:0]  out_tuser;  // status
  logic        cfg_we;
  logic        cfg_index;
  logic [8:0]  cfg_wdata;

  endf_value_table_interpolator DUT (.*);

  typedef struct packed {
    logic        op;
    logic [7:0]  slot;
    logic [39:0] energy;
    logic [31:0] value;
  } word_in_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } word_out_t;

  // directed row: expected typed in only where obvious
  typedef struct {
    word_in_t  w;
    bit        known;
    word_out_t want;
  } row_t;

  logic [39:0] pred_energy [TABLE_POINTS];
  logic [31:0] pred_value [TABLE_POINTS];
  logic [3:0]  pred_mode;
  logic [8:0]  pred_count;
  logic [63:0] root_c [17];

  word_out_t   results_due[$];
  int          errors;
  int          cycles;
  int          n_results;
  int          n_queries;
  bit          hold_off;
  bit          long_hold_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [63:0] sqrt_floor(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] fraction_q32(logic [63:0] num, logic [63:0] den);
    logic [63:0] r, q;
    if (num >= den) return 64'hFFFF_FFFF;
    r = num;
    q = 0;
    for (int k = 0; k < 32; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] mix(logic [63:0] a, logic [63:0] b, logic [63:0] t);
    logic [127:0] p;
    if (b >= a) begin
      p = (b - a) * t;
      return a + p[95:32];
    end
    p = (a - b) * t;
    return a - p[95:32];
  endfunction

  function automatic logic [63:0] log2_q16(logic [63:0] x);
    int k;
    logic [127:0] m;
    logic [63:0] f;
    k = 0;
    for (int j = 0; j < 64; j++) if (x[j]) k = j;
    m = (k >= 31) ? (x >> (k - 31)) : (x << (31 - k));
    f = 0;
    for (int j = 0; j < 16; j++) begin
      m = (m[63:0] * m[63:0]) >> 31;
      f = f << 1;
      if (m >= 128'h1_0000_0000) begin
        f[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(k) << 16) | f;
  endfunction

  function automatic logic [31:0] exp2_q16(logic [63:0] l);
    logic [127:0] p;
    logic [63:0] n, r;
    p = 128'h8000_0000;
    n = l >> 16;
    for (int j = 1; j <= 16; j++)
      if (l[16 - j]) p = (p[63:0] * root_c[j]) >> 31;
    if (n >= 31) begin
      if (n - 31 >= 32) return 32'hFFFF_FFFF;
      r = p[63:0] << (n - 31);
      if ((r >> (n - 31)) != p[63:0]) return 32'hFFFF_FFFF;
    end else begin
      r = p[63:0] >> (31 - n);
    end
    return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  function automatic word_out_t interpolate(word_in_t w);
    word_out_t o;
    int n, i;
    logic [63:0] e0, e1, v0, v1, t, l0, l1;
    o = '0;
    if (w.op == OP_WRITE) begin
      pred_energy[w.slot] = w.energy;
      pred_value[w.slot] = w.value;
      return o;
    end
    n = (pred_count > TABLE_POINTS) ? TABLE_POINTS : pred_count;
    for (i = 0; i < n; i++) if (pred_energy[i] > w.energy) break;
    if (i == 0) o.status = ST_BELOW;
    else if (i == n) o.status = ST_ABOVE;
    else begin
      e0 = pred_energy[i - 1];
      e1 = pred_energy[i];
      v0 = pred_value[i - 1];
      v1 = pred_value[i];
      t = fraction_q32(w.energy - e0, e1 - e0);
      if (pred_mode == MODE_LOGE) begin
        if (e0 == 0) o.status = ST_LOG0;
        else begin
          l0 = log2_q16(e0);
          l1 = log2_q16(e1);
          if (l1 > l0) t = fraction_q32(log2_q16(w.energy) - l0, l1 - l0);
          o.value = mix(v0, v1, t);
        end
      end else if (pred_mode == MODE_LOGV) begin
        if (v0 == 0 || v1 == 0) o.status = ST_LOG0;
        else o.value = exp2_q16(mix(log2_q16(v0), log2_q16(v1), t));
      end else begin
        o.value = mix(v0, v1, t);
      end
    end
    return o;
  endfunction

  task automatic report(string what, word_out_t got, word_out_t want);
    errors++;
    $display("mismatch %s: got value %h status %0d, want value %h status %0d",
             what, got.value, got.status, want.value, want.status);
  endtask

  // idle the input for a while; valid drops only when a gap is taken
  task automatic random_gap(int pct);
    int g;
    if ($urandom_range(99) >= pct) return;
    g = ($urandom_range(9) == 0) ? $urandom_range(40, 5) : $urandom_range(3, 1);
    in_tvalid <= 1'b0;
    repeat (g) @(posedge clk);
  endtask

  // send one word; expected result is queued at acceptance, valid stays up for the next
  task automatic send(word_in_t w, bit known, word_out_t want);
    word_out_t p;
    in_tvalid <= 1'b1;
    in_tuser  <= w.op;
    in_tdata  <= {w.value, w.energy, w.slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = interpolate(w);
    if (known && p != want) report("predictor vs table", p, want);
    if (known) p = want;
    results_due = {results_due, p};
    if (w.op == OP_QUERY) n_queries++;
  endtask

  task automatic set_reg(logic idx, logic [8:0] val);
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODE) pred_mode = val[3:0];
    else pred_count = val;
  endtask

  task automatic put(logic [7:0] s, logic [39:0] e, logic [31:0] v);
    word_in_t w;
    w = '{OP_WRITE, s, e, v};
    random_gap(20);
    send(w, 1'b0, '0);
  endtask

  task automatic ask(logic [39:0] e);
    word_in_t w;
    w = '{OP_QUERY, 8'($urandom), e, $urandom};
    random_gap(20);
    send(w, 1'b0, '0);
  endtask

  function automatic logic [39:0] rand_e();
    return {8'($urandom), 32'($urandom)};
  endfunction

  // non-decreasing table of n points starting at slot 0
  task automatic load_table(int n, bit zero_ok);
    logic [39:0] e, step;
    int sh;
    sh = $urandom_range(36, 4);
    e = zero_ok && $urandom_range(3) == 0 ? 0 : 40'($urandom_range(1000, 1));
    for (int k = 0; k < n; k++) begin
      put(8'(k), e, ($urandom_range(7) == 0 && zero_ok) ? 0 : $urandom);
      step = (rand_e() >> (40 - sh)) + ($urandom_range(3) == 0 ? 0 : 1);
      if (e + step < e) step = 0;
      e = e + step;
    end
  endtask

  // receiver: random stalls, one long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) < 75);
  end

  always @(posedge clk) begin
    word_out_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata, out_tuser};
      if (results_due.size() == 0) begin
        report("unexpected result word", got, '0);
      end else begin
        want = results_due.pop_front();
        n_results++;
        if (got.value != want.value) report("result_value", got, want);
        else if (got.status != want.status) report("status", got, want);
      end
    end
  end

  initial begin
    hold_off = 1'b0;
    long_hold_done = 1'b0;
    wait (n_queries >= 400);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
    long_hold_done = 1'b1;
  end

  row_t directed[$];

  initial begin
    int wait_n, n;
    errors = 0;
    cycles = 0;
    n_results = 0;
    n_queries = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_WRITE;
    cfg_we = 1'b0;
    cfg_index = REG_MODE;
    cfg_wdata = '0;
    pred_mode = MODE_RST;
    pred_count = 0;
    root_c[0] = 0;
    root_c[1] = sqrt_floor(64'h8000_0000_0000_0000);
    for (int j = 2; j <= 16; j++) root_c[j] = sqrt_floor(root_c[j - 1] << 31);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, then a small table with edge energies
    directed = '{
      '{'{OP_QUERY, 8'h00, 40'h0, 32'h0}, 1, '{32'h0, ST_BELOW}},
      '{'{OP_WRITE, 8'h00, 40'h0, 32'h0}, 1, '{32'h0, ST_OK}},
      '{'{OP_WRITE, 8'h01, 40'h100, 32'h0001_0000}, 1, '{32'h0, ST_OK}},
      '{'{OP_WRITE, 8'h02, 40'h200, 32'hFFFF_FFFF}, 1, '{32'h0, ST_OK}},
      '{'{OP_WRITE, 8'h03, 40'hFF_FFFF_FFFF, 32'h8000_0000}, 1, '{32'h0, ST_OK}},
      '{'{OP_WRITE, 8'hFF, 40'hAA_5555_AAAA, 32'h5A5A_A5A5}, 1, '{32'h0, ST_OK}}
    };
    foreach (directed[k]) send(directed[k].w, directed[k].known, directed[k].want);
    set_reg(REG_COUNT, 9'd4);
    directed = '{
      '{'{OP_QUERY, 8'h00, 40'h0, 32'h0}, 0, '{32'h0, ST_OK}},
      '{'{OP_QUERY, 8'hFF, 40'h80, 32'hFFFF_FFFF}, 0, '{32'h0, ST_OK}},
      '{'{OP_QUERY, 8'h00, 40'h180, 32'h0}, 0, '{32'h0, ST_OK}},
      '{'{OP_QUERY, 8'h00, 40'h1FF, 32'h0}, 0, '{32'h0, ST_OK}},
      '{'{OP_QUERY, 8'h00, 40'hFF_FFFF_FFFE, 32'h0}, 0, '{32'h0, ST_OK}},
      '{'{OP_QUERY, 8'h00, 40'hFF_FFFF_FFFF, 32'h0}, 1, '{32'h0, ST_ABOVE}}
    };
    foreach (directed[k]) send(directed[k].w, directed[k].known, directed[k].want);
    set_reg(REG_MODE, 9'(MODE_LOGE));
    send('{OP_QUERY, 8'h00, 40'h80, 32'h0}, 1, '{32'h0, ST_LOG0});
    send('{OP_QUERY, 8'h00, 40'h300, 32'h0}, 0, '0);
    send('{OP_QUERY, 8'h00, 40'h1_0000, 32'h0}, 0, '0);
    set_reg(REG_MODE, 9'(MODE_LOGV));
    send('{OP_QUERY, 8'h00, 40'h80, 32'h0}, 1, '{32'h0, ST_LOG0});
    send('{OP_QUERY, 8'h00, 40'h180, 32'h0}, 0, '0);
    send('{OP_QUERY, 8'h00, 40'h8000, 32'h0}, 0, '0);
    set_reg(REG_MODE, 9'd15);
    send('{OP_QUERY, 8'h00, 40'h150, 32'h0}, 0, '0);
    set_reg(REG_COUNT, 9'd0);
    send('{OP_QUERY, 8'h00, 40'h150, 32'h0}, 1, '{32'h0, ST_BELOW});

    // random phases: reload a table, pick mode and count, mostly in-range queries
    for (int ph = 0; ph < 40; ph++) begin
      n = (ph == 5) ? 256 : $urandom_range(12, 2);
      load_table(n, 1'b1);
      if (ph == 5) set_reg(REG_COUNT, 9'd256);
      else if (ph == 6) set_reg(REG_COUNT, 9'd256);  // slots stay written from phase 5
      else set_reg(REG_COUNT, 9'($urandom_range(n, n > 3 ? n - 2 : 2)));
      case ($urandom_range(3))
        0: set_reg(REG_MODE, 9'(MODE_LOGE));
        1: set_reg(REG_MODE, 9'(MODE_LOGV));
        2: set_reg(REG_MODE, 9'(MODE_RST));
        default: set_reg(REG_MODE, 9'(4'($urandom)));
      endcase
      for (int k = 0; k < ((ph == 5) ? 6 : 16); k++) begin
        n = (pred_count > TABLE_POINTS) ? TABLE_POINTS : pred_count;
        case ($urandom_range(9))
          0: ask(rand_e());
          1: ask(pred_energy[n - 1] + $urandom_range(2));
          2: ask(pred_energy[0] - $urandom_range(1));
          default: begin
            int s;
            s = $urandom_range(n - 2);
            ask(pred_energy[s] + ((pred_energy[s + 1] - pred_energy[s]) *
                $urandom_range(1000)) / 1000);
          end
        endcase
        // stray writes to slots 250..255, out of the search path except when the count is 256
        if ($urandom_range(9) == 0) put(8'($urandom_range(255, 250)), rand_e(), $urandom);
      end
    end
    in_tvalid <= 1'b0;

    wait_n = 0;
    while (results_due.size() != 0 && wait_n < 200_000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (300) @(posedge clk);
    $display("run covered %0d result words, %0d queries over all modes and counts 0..256",
             n_results, n_queries);
    $display("long output hold-off %s", long_hold_done ? "exercised" : "not reached");
    if (errors == 0 && results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d errors, %0d results outstanding", errors, results_due.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
